// File: src/pbgc_pkg.sv
// ----------------------------------------------------------------------------
// pbgc_pkg: shared types, constants and functions
// PRBS15 (x^15 + x^14 + 1) byte generator and checker: register map,
// seed conditioning, eight-step unrolled shift and byte popcount.
// ----------------------------------------------------------------------------
`default_nettype none

package pbgc_pkg;

	localparam int unsigned LFSR_W  = 15;
	localparam int unsigned BYTE_W  = 8;
	localparam int unsigned CNT_W   = 16;
	localparam int unsigned SEED_W  = 16;
	localparam int unsigned APB_AW  = 3;
	localparam int unsigned APB_DW  = 32;

	localparam logic [SEED_W-1:0] SEED_MASK = 16'h5A5A;
	localparam int unsigned       TAP_HI    = 14;
	localparam int unsigned       TAP_LO    = 13;

	// Register index taken from paddr[2]
	localparam logic REG_SEED = 1'b0;

	// Item kinds
	localparam logic KIND_GEN   = 1'b0;
	localparam logic KIND_CHECK = 1'b1;

	// Control between the top level and the state holders
	typedef struct packed {
		logic advance;   // an input beat was taken this cycle
		logic restart;   // reload the register and clear the counts
	} ctrl_t;

	typedef struct packed {
		logic [BYTE_W-1:0] pattern;
		logic [LFSR_W-1:0] state;
	} lfsr_step_t;

	// Start value of a run
	function automatic logic [LFSR_W-1:0] seed_init(input logic [SEED_W-1:0] seed);
		logic [SEED_W-1:0] v;
		v = (seed ^ SEED_MASK) | 16'h0001;
		return v[LFSR_W-1:0];
	endfunction

	// Eight register steps; new bits gathered MSB first
	function automatic lfsr_step_t lfsr_step8(input logic [LFSR_W-1:0] s);
		lfsr_step_t r;
		logic       nb;
		r.state   = s;
		r.pattern = '0;
		for (int i = 0; i < BYTE_W; i++) begin
			nb        = r.state[TAP_HI] ^ r.state[TAP_LO];
			r.state   = {r.state[LFSR_W-2:0], nb};
			r.pattern = {r.pattern[BYTE_W-2:0], nb};
		end
		return r;
	endfunction

	function automatic logic [3:0] ones8(input logic [BYTE_W-1:0] v);
		logic [3:0] n;
		n = '0;
		for (int i = 0; i < BYTE_W; i++) begin
			n = n + {3'b000, v[i]};
		end
		return n;
	endfunction

endpackage

`default_nettype wire

// File: src/pbgc_if.sv
// ----------------------------------------------------------------------------
// pbgc_if: stream channels of the PRBS15 generator and checker
// Valid/ready channels for input items and result items.
// ----------------------------------------------------------------------------
`default_nettype none

interface pbgc_in_if;
	logic       valid;
	logic       ready;
	logic       kind;
	logic [7:0] data_byte;
	logic       last;

	modport source (output valid, kind, data_byte, last, input ready);
	modport sink   (input valid, kind, data_byte, last, output ready);
endinterface

interface pbgc_out_if;
	logic        valid;
	logic        ready;
	logic [7:0]  pattern_byte;
	logic [7:0]  error_bits;
	logic [15:0] err_bit_count;
	logic [15:0] bad_bytes;
	logic        run_end;

	modport source (output valid, pattern_byte, error_bits, err_bit_count, bad_bytes, run_end,
		input ready);
	modport sink   (input valid, pattern_byte, error_bits, err_bit_count, bad_bytes, run_end,
		output ready);
endinterface

`default_nettype wire

// File: src/pbgc_lfsr.sv
// ----------------------------------------------------------------------------
// pbgc_lfsr: PRBS15 shift register
// Holds the pattern register, steps it eight times per beat and reloads it
// from the seed at the start of each run.
// ----------------------------------------------------------------------------
`default_nettype none

module pbgc_lfsr
	import pbgc_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire ctrl_t             ctrl,
	input  wire logic [SEED_W-1:0] seed,
	output logic      [BYTE_W-1:0] pattern,
	output logic      [LFSR_W-1:0] state
);

	logic [LFSR_W-1:0] lfsr_q;
	lfsr_step_t        step;

	// Unrolled eight steps
	assign step    = lfsr_step8(lfsr_q);
	assign pattern = step.pattern;
	assign state   = lfsr_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lfsr_q <= seed_init('0);
		end else if (ctrl.restart) begin
			lfsr_q <= seed_init(seed);
		end else if (ctrl.advance) begin
			lfsr_q <= step.state;
		end
	end

endmodule

`default_nettype wire

// File: src/pbgc_check.sv
// ----------------------------------------------------------------------------
// pbgc_check: received byte comparison and error counts
// Compares the received byte with the pattern and keeps the wrapping
// bad-byte and bit-error counts of the current run.
// ----------------------------------------------------------------------------
`default_nettype none

module pbgc_check
	import pbgc_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire ctrl_t             ctrl,
	input  wire logic              kind,
	input  wire logic [BYTE_W-1:0] data_byte,
	input  wire logic [BYTE_W-1:0] pattern,
	output logic      [BYTE_W-1:0] error_bits,
	output logic      [CNT_W-1:0]  err_bit_count,
	output logic      [CNT_W-1:0]  bad_bytes
);

	logic [CNT_W-1:0] bit_total_q;
	logic [CNT_W-1:0] bad_total_q;
	logic             mismatch;

	// Difference is only meaningful for check items
	assign error_bits = (kind == KIND_CHECK) ? (pattern ^ data_byte) : '0;
	assign mismatch   = |error_bits;

	// Counts including this beat
	assign err_bit_count = bit_total_q + {{(CNT_W-4){1'b0}}, ones8(error_bits)};
	assign bad_bytes     = bad_total_q + {{(CNT_W-1){1'b0}}, mismatch};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bit_total_q <= '0;
			bad_total_q <= '0;
		end else if (ctrl.restart) begin
			bit_total_q <= '0;
			bad_total_q <= '0;
		end else if (ctrl.advance) begin
			bit_total_q <= err_bit_count;
			bad_total_q <= bad_bytes;
		end
	end

endmodule

`default_nettype wire

// File: src/prbs15_byte_generator_checker.sv
// The result beat of an accepted input beat is valid in the cycle after it.
// Throughput: one item per cycle while the result channel is not stalled; the eight register steps are unrolled
// between the state registers and the result register.
// Reset: the seed clears to zero, the register loads (0 ^ 0x5A5A) | 1,
// both counts clear and the result register is empty.
// ----------------------------------------------------------------------------
// prbs15_byte_generator_checker: PRBS15 byte generator and checker
// Generates one pattern byte per item or checks a received byte against
// it, with an APB seed register that starts a new run when written.
// ----------------------------------------------------------------------------
`default_nettype none

module prbs15_byte_generator_checker
	import pbgc_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	pbgc_in_if.sink                in_item,
	pbgc_out_if.source             out_item,
	input  wire logic              psel,
	input  wire logic              penable,
	input  wire logic              pwrite,
	input  wire logic [APB_AW-1:0] paddr,
	input  wire logic [APB_DW-1:0] pwdata,
	output logic      [APB_DW-1:0] prdata,
	output logic                   pready
);

	logic [SEED_W-1:0] seed_q;
	logic [SEED_W-1:0] seed_load;
	logic              cfg_wr;
	logic              in_acc;
	logic              load;
	ctrl_t             ctrl;
	logic [BYTE_W-1:0] pattern;
	logic [LFSR_W-1:0] lfsr_state;
	logic [BYTE_W-1:0] error_bits;
	logic [CNT_W-1:0]  err_bit_count;
	logic [CNT_W-1:0]  bad_bytes;

	logic              out_valid_q;
	logic [BYTE_W-1:0] pattern_q;
	logic [BYTE_W-1:0] error_bits_q;
	logic [CNT_W-1:0]  err_bit_count_q;
	logic [CNT_W-1:0]  bad_bytes_q;
	logic              run_end_q;

	// APB register port
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_SEED);
	assign prdata = (paddr[2] == REG_SEED) ? {{(APB_DW-SEED_W){1'b0}}, seed_q} : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seed_q <= '0;
		end else if (cfg_wr) begin
			seed_q <= pwdata[SEED_W-1:0];
		end
	end

	// Handshake: take a beat whenever the result register is free or draining
	assign load            = !out_valid_q || out_item.ready;
	assign in_item.ready   = load;
	assign in_acc          = in_item.valid && load;

	assign seed_load    = cfg_wr ? pwdata[SEED_W-1:0] : seed_q;
	assign ctrl.advance = in_acc;
	assign ctrl.restart = cfg_wr || (in_acc && in_item.last);

	pbgc_lfsr u_lfsr (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctrl    (ctrl),
		.seed    (seed_load),
		.pattern (pattern),
		.state   (lfsr_state)
	);

	pbgc_check u_check (
		.clk           (clk),
		.arst_n        (arst_n),
		.ctrl          (ctrl),
		.kind          (in_item.kind),
		.data_byte     (in_item.data_byte),
		.pattern       (pattern),
		.error_bits    (error_bits),
		.err_bit_count (err_bit_count),
		.bad_bytes     (bad_bytes)
	);

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load) begin
			out_valid_q <= in_item.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			pattern_q       <= pattern;
			error_bits_q    <= error_bits;
			err_bit_count_q <= err_bit_count;
			bad_bytes_q     <= bad_bytes;
			run_end_q       <= in_item.last;
		end
	end

	assign out_item.valid         = out_valid_q;
	assign out_item.pattern_byte  = pattern_q;
	assign out_item.error_bits    = error_bits_q;
	assign out_item.err_bit_count = err_bit_count_q;
	assign out_item.bad_bytes     = bad_bytes_q;
	assign out_item.run_end       = run_end_q;

`ifndef SYNTHESIS
	// An empty result register never holds off the input
	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid_q |-> in_item.ready)
		else $error("input stalled with empty result register");

	// A generate beat yields a result with no error bits
	a_gen_no_errors: assert property (@(posedge clk) disable iff (!arst_n)
		(in_acc && (in_item.kind == KIND_GEN)) |=> (out_valid_q && (error_bits_q == '0)))
		else $error("generate beat produced error bits");

	// After the last beat of a run the register restarts from the seed
	a_last_reload: assert property (@(posedge clk) disable iff (!arst_n)
		(in_acc && in_item.last && !cfg_wr) |=> (lfsr_state == seed_init(seed_q)))
		else $error("register not reloaded after last beat");

	// A seed write restarts the register from the written value
	a_seed_reload: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_wr |=> (lfsr_state == seed_init($past(pwdata[SEED_W-1:0]))))
		else $error("register not reloaded after seed write");
`endif

endmodule

`default_nettype wire

// File: verif/prbs15_byte_generator_checker_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prbs15_byte_generator_checker_tb: self-checking bench for the PRBS15 block
// Drives generate and check beats through the input channel and writes the
// seed over APB. A PRBS15 model in the bench predicts every result beat,
// and each beat is compared field by field in order of arrival. Both
// channels stall at random in several mixes.
// ----------------------------------------------------------------------------

module prbs15_byte_generator_checker_tb;
	import pbgc_pkg::*;

	localparam int unsigned CYCLE_LIMIT    = 1_000_000;
	localparam int unsigned RANDOM_ITEMS   = 1300;
	localparam int unsigned LONG_RUN_ITEMS = 100;
	localparam logic [APB_AW-1:0] SEED_ADDR = {REG_SEED, 2'b00};

	typedef struct {
		logic [7:0]  pattern;
		logic [7:0]  err_bits;
		logic [15:0] bit_err;
		logic [15:0] bad;
		logic        run_end;
	} prbs_result_t;

	logic clk;
	logic arst_n;
	logic psel;
	logic penable;
	logic pwrite;
	logic [APB_AW-1:0] paddr;
	logic [APB_DW-1:0] pwdata;
	logic [APB_DW-1:0] prdata;
	logic pready;

	pbgc_in_if  in_chan ();
	pbgc_out_if out_chan ();

	prbs15_byte_generator_checker DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_item  (in_chan),
		.out_item (out_chan),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready)
	);

	// Bench copy of the pattern state and the run counts
	logic [14:0] prbs_reg;
	logic [15:0] seed_copy;
	logic [15:0] bit_err_total;
	logic [15:0] bad_byte_count;
	prbs_result_t pending_results[$];

	int unsigned fail_count;
	int unsigned cycle_count;
	int unsigned send_idle_pct;
	int unsigned recv_idle_pct;

	// Clock
	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// Start value of a run from the seed
	function automatic logic [14:0] run_start_value(input logic [15:0] s);
		logic [15:0] v;
		v = (s ^ SEED_MASK) | 16'h0001;
		return v[14:0];
	endfunction

	// Eight shifts of x^15 + x^14 + 1; returns {next state, pattern byte}
	function automatic logic [22:0] prbs_advance(input logic [14:0] s);
		logic [7:0] pat;
		logic       nb;
		pat = '0;
		for (int i = 0; i < 8; i++) begin
			nb  = s[TAP_HI] ^ s[TAP_LO];
			s   = {s[13:0], nb};
			pat = {pat[6:0], nb};
		end
		return {s, pat};
	endfunction

	function automatic logic [7:0] upcoming_pattern();
		logic [22:0] r;
		r = prbs_advance(prbs_reg);
		return r[7:0];
	endfunction

	task automatic begin_run();
		prbs_reg       = run_start_value(seed_copy);
		bit_err_total  = '0;
		bad_byte_count = '0;
	endtask

	// Update the model for one accepted beat and queue its result
	task automatic record_expected(input logic kind, input logic [7:0] rx, input logic last);
		logic [22:0]  r;
		prbs_result_t e;
		r        = prbs_advance(prbs_reg);
		prbs_reg = r[22:8];
		e.pattern  = r[7:0];
		e.err_bits = '0;
		if (kind == KIND_CHECK) begin
			e.err_bits = r[7:0] ^ rx;
			if (e.err_bits != 8'h00) begin
				bad_byte_count = bad_byte_count + 16'd1;
				bit_err_total  = bit_err_total + 16'($countones(e.err_bits));
			end
		end
		e.bit_err = bit_err_total;
		e.bad     = bad_byte_count;
		e.run_end = last;
		pending_results.push_back(e);
		if (last)
			begin_run();
	endtask

	task automatic report_mismatch(input string what, input logic [31:0] got,
		input logic [31:0] want);
		$display("%0t mismatch on %s: got 0x%0h, expected 0x%0h", $realtime, what, got, want);
		fail_count++;
	endtask

	// Receiver: random stalls and in-order comparison of result beats
	initial out_chan.ready = 1'b0;

	always @(posedge clk) begin
		prbs_result_t e;
		out_chan.ready <= ($urandom_range(99) >= recv_idle_pct);
		if (arst_n && out_chan.valid && out_chan.ready) begin
			if (pending_results.size() == 0) begin
				report_mismatch("unexpected result beat", {24'h0, out_chan.pattern_byte},
					32'h0);
			end else begin
				e = pending_results.pop_front();
				if (out_chan.pattern_byte !== e.pattern)
					report_mismatch("pattern_byte", 32'(out_chan.pattern_byte),
						32'(e.pattern));
				if (out_chan.error_bits !== e.err_bits)
					report_mismatch("error_bits", 32'(out_chan.error_bits),
						32'(e.err_bits));
				if (out_chan.err_bit_count !== e.bit_err)
					report_mismatch("err_bit_count", 32'(out_chan.err_bit_count),
						32'(e.bit_err));
				if (out_chan.bad_bytes !== e.bad)
					report_mismatch("bad_bytes", 32'(out_chan.bad_bytes), 32'(e.bad));
				if (out_chan.run_end !== e.run_end)
					report_mismatch("run_end", 32'(out_chan.run_end), 32'(e.run_end));
			end
		end
	end

	// Watchdog
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	// Send one beat, with idle cycles before it at the sender's idle rate
	task automatic send_item(input logic kind, input logic [7:0] rx, input logic last);
		if ($urandom_range(99) < send_idle_pct) begin
			in_chan.valid     <= 1'b0;
			in_chan.data_byte <= 8'($urandom);
			do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
		end
		in_chan.valid     <= 1'b1;
		in_chan.kind      <= kind;
		in_chan.data_byte <= rx;
		in_chan.last      <= last;
		do @(posedge clk); while (!in_chan.ready);
		record_expected(kind, rx, last);
	endtask

	// Stop sending and wait until every result has come back
	task automatic drain();
		in_chan.valid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (3) @(posedge clk);
	endtask

	// One APB transfer; leaves psel high, the caller lowers it
	task automatic apb_access(input logic wr, input logic [31:0] wdata,
		output logic [31:0] rdata);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= wr;
		paddr   <= SEED_ADDR;
		pwdata  <= wdata;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		rdata = prdata;
	endtask

	task automatic read_seed_back();
		logic [31:0] rd;
		apb_access(1'b0, 32'h0, rd);
		psel    <= 1'b0;
		penable <= 1'b0;
		if (rd !== {16'h0, seed_copy})
			report_mismatch("seed readback", rd, {16'h0, seed_copy});
	endtask

	// Seed write while idle, followed by a readback
	task automatic write_seed(input logic [31:0] value);
		logic [31:0] rd;
		drain();
		apb_access(1'b1, value, rd);
		seed_copy = value[15:0];
		begin_run();
		read_seed_back();
		@(posedge clk);
	endtask

	// Random beat of either kind: half matching bytes, a quarter with one bit flipped, a quarter noise
	task automatic send_random_item();
		logic       kind;
		logic [7:0] rx;
		logic       last;
		kind = 1'($urandom_range(1));
		case ($urandom_range(3))
			0, 1: rx = upcoming_pattern();
			2:    rx = upcoming_pattern() ^ (8'h01 << $urandom_range(7));
			default: rx = 8'($urandom);
		endcase
		last = ($urandom_range(19) == 0);
		send_item(kind, rx, last);
	endtask

	// ---- tests ----

	// Pattern from the reset seed
	task automatic test_reset_seed();
		read_seed_back();
		send_item(KIND_GEN, 8'hFF, 1'b0);
		send_item(KIND_GEN, 8'h00, 1'b0);
		send_item(KIND_CHECK, upcoming_pattern(), 1'b0);
		drain();
	endtask

	// Field extremes, mixed kinds, run ends and mid-run seed writes
	task automatic test_directed();
		send_item(KIND_CHECK, upcoming_pattern(), 1'b0);
		send_item(KIND_CHECK, ~upcoming_pattern(), 1'b0);
		send_item(KIND_GEN, 8'hA5, 1'b0);
		send_item(KIND_CHECK, 8'h00, 1'b0);
		send_item(KIND_CHECK, 8'hFF, 1'b0);
		send_item(KIND_GEN, 8'h00, 1'b1);
		send_item(KIND_CHECK, ~upcoming_pattern(), 1'b1);
		send_item(KIND_CHECK, upcoming_pattern() ^ 8'h80, 1'b0);
		// seed written partway through a run
		write_seed({16'hFFFF, 16'hFFFF});
		send_item(KIND_CHECK, upcoming_pattern() ^ 8'h01, 1'b0);
		send_item(KIND_GEN, 8'hFF, 1'b0);
		// seed giving a start state of one
		write_seed(32'h0000_5A5A);
		send_item(KIND_GEN, 8'h00, 1'b0);
		send_item(KIND_CHECK, upcoming_pattern(), 1'b1);
		write_seed(32'h0000_5A5B);
		send_item(KIND_GEN, 8'h00, 1'b0);
		// seed giving an all-ones start state
		write_seed(32'h0000_A5A5);
		send_item(KIND_GEN, 8'h00, 1'b0);
		send_item(KIND_CHECK, 8'h55, 1'b0);
		send_item(KIND_CHECK, 8'hAA, 1'b1);
		write_seed(32'h0000_0000);
		send_item(KIND_GEN, 8'h00, 1'b0);
		drain();
	endtask

	// One long run of bad bytes back to back; both counts build up over it
	task automatic test_long_run();
		send_idle_pct = 0;
		recv_idle_pct = 0;
		write_seed($urandom);
		for (int i = 0; i < LONG_RUN_ITEMS; i++)
			send_item(KIND_CHECK, upcoming_pattern() ^ 8'($urandom_range(1, 255)),
				i == LONG_RUN_ITEMS - 1);
		drain();
	endtask

	// Random traffic in three stall mixes, a new seed before each
	task automatic test_random_traffic();
		int unsigned tx_mix[3] = '{30, 70, 0};
		int unsigned rx_mix[3] = '{70, 30, 0};
		for (int p = 0; p < 3; p++) begin
			send_idle_pct = tx_mix[p];
			recv_idle_pct = rx_mix[p];
			write_seed((p == 2) ? 32'h0000_FFFF : $urandom);
			for (int i = 0; i < RANDOM_ITEMS / 3; i++)
				send_random_item();
		end
		drain();
	endtask

	// Main sequence
	initial begin
		fail_count    = 0;
		cycle_count   = 0;
		send_idle_pct = 30;
		recv_idle_pct = 70;
		seed_copy     = '0;
		begin_run();
		arst_n            <= 1'b0;
		in_chan.valid     <= 1'b0;
		in_chan.kind      <= KIND_GEN;
		in_chan.data_byte <= 8'h00;
		in_chan.last      <= 1'b0;
		psel              <= 1'b0;
		penable           <= 1'b0;
		pwrite            <= 1'b0;
		paddr             <= '0;
		pwdata            <= '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_seed();
		test_directed();
		test_long_run();
		test_random_traffic();

		repeat (5) @(posedge clk);
		if (fail_count == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

endmodule

// File: filelist.f
src/pbgc_pkg.sv
src/pbgc_if.sv
src/pbgc_lfsr.sv
src/pbgc_check.sv
src/prbs15_byte_generator_checker.sv
verif/prbs15_byte_generator_checker_tb.sv
